@@ sv/tbo_pkg.sv @@
// Shared constants for the triangle/box overlap test unit.
package tbo_pkg;

  localparam int HALF_BITS      = 23;
  localparam int COORD_BITS_DEF = 24;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(2048);

  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_Z = 2'd2;

endpackage

@@ sv/triangle_box_overlap_test_unit.sv @@
// Pipelined separating-axis overlap test of a triangle against an axis-aligned box.
//
// Usage:
//   Input: raise start with the box center and three triangle vertices on the in_
//   ports; the beat is taken at any edge where start is high and busy is low. busy
//   stays low, so a new beat may enter on every cycle.
//   Output: out_valid pulses for one cycle with out_overlaps (1 = overlap, touching
//   counts). out_valid rises once the beat has passed all six register stages, and
//   results come out in input order.
//   Throughput is one beat per cycle; the six register stages are vertex translate,
//   products, differences, range checks with split plane products, plane sums and
//   the final compare.
//   Configuration: cfg_we writes cfg_wdata to the half extent selected by cfg_index
//   (0 = x, 1 = y, 2 = z, others ignored); write only while no beat is in flight.
//   Reset: synchronous active-low rst_n empties the pipeline and sets every half
//   extent to 0.5 (Q11.12). The receiver cannot stall; results are never held back.
module triangle_box_overlap_test_unit #(
  parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_BITS-1:0]      in_center_x,
  input  logic signed [COORD_BITS-1:0]      in_center_y,
  input  logic signed [COORD_BITS-1:0]      in_center_z,
  input  logic signed [COORD_BITS-1:0]      in_vert_a_x,
  input  logic signed [COORD_BITS-1:0]      in_vert_a_y,
  input  logic signed [COORD_BITS-1:0]      in_vert_a_z,
  input  logic signed [COORD_BITS-1:0]      in_vert_b_x,
  input  logic signed [COORD_BITS-1:0]      in_vert_b_y,
  input  logic signed [COORD_BITS-1:0]      in_vert_b_z,
  input  logic signed [COORD_BITS-1:0]      in_vert_c_x,
  input  logic signed [COORD_BITS-1:0]      in_vert_c_y,
  input  logic signed [COORD_BITS-1:0]      in_vert_c_z,
  input  logic                              cfg_we,
  input  logic [tbo_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tbo_pkg::HALF_BITS-1:0]     cfg_wdata,
  output logic                              out_valid,
  output logic                              out_overlaps
);
  import tbo_pkg::*;

  localparam int HW  = HALF_BITS;
  localparam int VW  = COORD_BITS + 1;         // translated vertex
  localparam int EW  = COORD_BITS + 2;         // edge
  localparam int PW  = EW + VW;                // projection product
  localparam int RDW = EW + HW + 1;            // edge-axis radius
  localparam int XW  = ((PW + 1 > RDW) ? PW + 1 : RDW) + 1;
  localparam int NW  = 2 * EW + 1;             // plane normal
  localparam int SPL = (NW + 1) / 2;           // split point of the normal
  localparam int DLW = SPL + 1 + VW;
  localparam int DHW = NW - SPL + VW;
  localparam int RLW = SPL + HW;
  localparam int RHW = NW - SPL + HW;
  localparam int DW  = NW + VW + 2;
  localparam int RW  = NW + HW + 2;
  localparam int FW  = (DW > RW) ? DW : RW;

  function automatic logic rsep(input logic signed [XW-1:0] a, input logic signed [XW-1:0] b,
                                input logic signed [XW-1:0] c, input logic signed [XW-1:0] r);
    logic signed [XW-1:0] mn, mx;
    mn = a;
    mx = a;
    if (b < mn) mn = b;
    if (c < mn) mn = c;
    if (b > mx) mx = b;
    if (c > mx) mx = c;
    return (mn > r) || (mx < -r);
  endfunction

  // configuration
  logic [HW-1:0] half_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r[0] <= HALF_RESET;
      half_r[1] <= HALF_RESET;
      half_r[2] <= HALF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_X: half_r[0] <= cfg_wdata;
        CFG_HALF_Y: half_r[1] <= cfg_wdata;
        CFG_HALF_Z: half_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic vld_r [1:6];
  logic acc;
  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= 6; s++) vld_r[s] <= 1'b0;
    end else begin
      vld_r[1] <= acc;
      for (int s = 2; s <= 6; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // stage 1: translate into box frame, form edges
  logic signed [COORD_BITS-1:0] vin [3][3];
  logic signed [COORD_BITS-1:0] cin [3];
  logic signed [VW-1:0] v_nxt [3][3];
  logic signed [EW-1:0] e_nxt [3][3];
  logic signed [VW-1:0] v1_r [3][3];
  logic signed [EW-1:0] e1_r [3][3];

  assign cin = '{in_center_x, in_center_y, in_center_z};
  assign vin = '{'{in_vert_a_x, in_vert_a_y, in_vert_a_z},
                 '{in_vert_b_x, in_vert_b_y, in_vert_b_z},
                 '{in_vert_c_x, in_vert_c_y, in_vert_c_z}};

  always_comb begin
    for (int j = 0; j < 3; j++)
      for (int c = 0; c < 3; c++)
        v_nxt[j][c] = VW'(vin[j][c]) - VW'(cin[c]);
    for (int i = 0; i < 3; i++)
      for (int c = 0; c < 3; c++)
        e_nxt[i][c] = EW'(v_nxt[(i+1)%3][c]) - EW'(v_nxt[i][c]);
  end

  always_ff @(posedge clk) begin
    v1_r <= v_nxt;
    e1_r <= e_nxt;
  end

  // stage 2: all products, box-axis check
  logic signed [PW-1:0]     pa_nxt [3][3][3];
  logic signed [PW-1:0]     pb_nxt [3][3][3];
  logic [EW+HW-1:0]         ra_nxt [3][3];
  logic [EW+HW-1:0]         rb_nxt [3][3];
  logic signed [2*EW-1:0]   na_nxt [3];
  logic signed [2*EW-1:0]   nb_nxt [3];
  logic                     boxsep_nxt;
  logic signed [PW-1:0]     pa2_r [3][3][3];
  logic signed [PW-1:0]     pb2_r [3][3][3];
  logic [EW+HW-1:0]         ra2_r [3][3];
  logic [EW+HW-1:0]         rb2_r [3][3];
  logic signed [2*EW-1:0]   na2_r [3];
  logic signed [2*EW-1:0]   nb2_r [3];
  logic                     boxsep2_r;
  logic signed [VW-1:0]     v0_2_r [3];

  always_comb begin
    logic [EW-1:0] ae_u, ae_w;
    int u, w;
    boxsep_nxt = 1'b0;
    for (int c = 0; c < 3; c++)
      boxsep_nxt = boxsep_nxt |
                   rsep(XW'(v1_r[0][c]), XW'(v1_r[1][c]), XW'(v1_r[2][c]),
                        $signed({{(XW-HW){1'b0}}, half_r[c]}));
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        u = (k + 1) % 3;
        w = (k + 2) % 3;
        ae_u = e1_r[i][u][EW-1] ? EW'(-e1_r[i][u]) : EW'(e1_r[i][u]);
        ae_w = e1_r[i][w][EW-1] ? EW'(-e1_r[i][w]) : EW'(e1_r[i][w]);
        ra_nxt[i][k] = ae_w * half_r[u];
        rb_nxt[i][k] = ae_u * half_r[w];
        for (int j = 0; j < 3; j++) begin
          pa_nxt[i][k][j] = e1_r[i][u] * v1_r[j][w];
          pb_nxt[i][k][j] = e1_r[i][w] * v1_r[j][u];
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      na_nxt[c] = e1_r[0][(c+1)%3] * e1_r[1][(c+2)%3];
      nb_nxt[c] = e1_r[0][(c+2)%3] * e1_r[1][(c+1)%3];
    end
  end

  always_ff @(posedge clk) begin
    pa2_r     <= pa_nxt;
    pb2_r     <= pb_nxt;
    ra2_r     <= ra_nxt;
    rb2_r     <= rb_nxt;
    na2_r     <= na_nxt;
    nb2_r     <= nb_nxt;
    boxsep2_r <= boxsep_nxt;
    v0_2_r    <= v1_r[0];
  end

  // stage 3: projections, radii, normal
  logic signed [PW:0]     p3_r [3][3][3];
  logic [RDW-1:0]         rad3_r [3][3];
  logic signed [NW-1:0]   n3_r [3];
  logic                   boxsep3_r;
  logic signed [VW-1:0]   v0_3_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        rad3_r[i][k] <= RDW'(ra2_r[i][k]) + RDW'(rb2_r[i][k]);
        for (int j = 0; j < 3; j++)
          p3_r[i][k][j] <= (PW+1)'(pa2_r[i][k][j]) - (PW+1)'(pb2_r[i][k][j]);
      end
    for (int c = 0; c < 3; c++)
      n3_r[c] <= NW'(na2_r[c]) - NW'(nb2_r[c]);
    boxsep3_r <= boxsep2_r;
    v0_3_r    <= v0_2_r;
  end

  // stage 4: edge-axis range checks, split plane products
  logic                     edgesep_nxt;
  logic [NW-1:0]            an_nxt [3];
  logic                     sep4_r;
  logic signed [DLW-1:0]    dlo4_r [3];
  logic signed [DHW-1:0]    dhi4_r [3];
  logic [RLW-1:0]           rlo4_r [3];
  logic [RHW-1:0]           rhi4_r [3];
  logic                     edgesep4_r;

  always_comb begin
    edgesep_nxt = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        edgesep_nxt = edgesep_nxt |
                      rsep(XW'(p3_r[i][k][0]), XW'(p3_r[i][k][1]), XW'(p3_r[i][k][2]),
                           $signed({{(XW-RDW){1'b0}}, rad3_r[i][k]}));
    for (int c = 0; c < 3; c++)
      an_nxt[c] = n3_r[c][NW-1] ? NW'(-n3_r[c]) : NW'(n3_r[c]);
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      dlo4_r[c] <= $signed({1'b0, n3_r[c][SPL-1:0]}) * v0_3_r[c];
      dhi4_r[c] <= $signed(n3_r[c][NW-1:SPL]) * v0_3_r[c];
      rlo4_r[c] <= an_nxt[c][SPL-1:0] * half_r[c];
      rhi4_r[c] <= an_nxt[c][NW-1:SPL] * half_r[c];
    end
    edgesep4_r <= edgesep_nxt;
    sep4_r     <= boxsep3_r | edgesep_nxt;
  end

  // stage 5: plane distance and radius
  logic signed [DW-1:0] d_nxt;
  logic [RW-1:0]        r_nxt;
  logic signed [DW-1:0] d5_r;
  logic [RW-1:0]        r5_r;
  logic                 sep5_r;

  always_comb begin
    d_nxt = '0;
    r_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      d_nxt = d_nxt + (DW'(dhi4_r[c]) <<< SPL) + DW'(dlo4_r[c]);
      r_nxt = r_nxt + (RW'(rhi4_r[c]) << SPL) + RW'(rlo4_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    d5_r   <= d_nxt;
    r5_r   <= r_nxt;
    sep5_r <= sep4_r;
  end

  // stage 6: plane compare
  logic [DW-1:0] ad;
  logic          planesep;
  logic          ov_r;

  assign ad       = d5_r[DW-1] ? DW'(-d5_r) : DW'(d5_r);
  assign planesep = FW'(ad) > FW'(r5_r);

  always_ff @(posedge clk) begin
    ov_r <= !(sep5_r || planesep);
  end

  assign out_valid    = vld_r[6];
  assign out_overlaps = ov_r;

`ifndef SYNTHESIS
  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[5]))
    else $error("result strobe without item in last stage");

  a_box_sep: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && boxsep3_r) |-> ##3 (out_valid && !out_overlaps))
    else $error("box-axis separation lost");

  a_edge_sep: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && edgesep4_r) |-> ##2 (out_valid && !out_overlaps))
    else $error("edge-axis separation lost");
`endif

endmodule
